// ===== sv/morse_key_text_decoder_macros.svh =====
// assertion macros shared by the morse key text decoder rtl
`ifndef MORSE_KEY_TEXT_DECODER_MACROS_SVH
`define MORSE_KEY_TEXT_DECODER_MACROS_SVH

// check on every clock edge outside reset
`define MKTD_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// check on every clock edge, reset included
`define MKTD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== sv/mktd_pkg.sv =====
// types, constants and the morse code table of the morse key text decoder
`timescale 1ns / 1ps

package mktd_pkg;

    localparam int TEXT_CAPACITY = 16;
    localparam int SYMBOL_MAX    = 6;
    localparam int CODE_COUNT    = 36;

    localparam int TEXT_LEN_W = 5;
    localparam int SYM_LEN_W  = 3;
    localparam int SYM_W      = 6;
    localparam int CHAR_W     = 8;
    localparam int PADDR_W    = 2;
    localparam int PDATA_W    = 32;

    localparam logic [PADDR_W-1:0] ADDR_BACK_ENABLE = 2'd0;

    localparam logic [CHAR_W-1:0] CHAR_SPACE = " ";
    localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'd0;

    // six dots and six dashes as pending patterns
    localparam logic [SYM_W-1:0] PATTERN_DOTS  = 6'h00;
    localparam logic [SYM_W-1:0] PATTERN_DASHES = 6'h3f;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_APPEND  = 3'd1,
        EV_DELETE  = 3'd2,
        EV_CLEAR   = 3'd3,
        EV_RESTART = 3'd4
    } t_text_event;

    typedef struct packed {
        logic                 dash_level;
        logic                 dot_level;
        logic                 space_level;
        logic                 back_level;
    } t_keys;

    typedef struct packed {
        logic                  prev_dash;
        logic                  prev_dot;
        logic                  prev_space;
        logic [SYM_W-1:0]      sym_bits;
        logic [SYM_LEN_W-1:0]  sym_count;
        logic [TEXT_LEN_W-1:0] text_count;
    } t_state;

    typedef struct packed {
        t_text_event           text_event;
        logic [CHAR_W-1:0]     text_char;
        logic                  back_deleted;
        logic [TEXT_LEN_W-1:0] text_length;
        logic [SYM_LEN_W-1:0]  symbol_length;
        logic [SYM_W-1:0]      symbol_pattern;
    } t_result;

    typedef struct packed {
        logic [SYM_LEN_W-1:0] len;
        logic [SYM_W-1:0]     bits;
        logic [CHAR_W-1:0]    ch;
    } t_code;

    // itu morse, bit i set for a dash at position i
    localparam t_code MORSE_TABLE [CODE_COUNT] = '{
        '{3'd2, 6'd2,  "A"}, '{3'd4, 6'd1,  "B"}, '{3'd4, 6'd5,  "C"},
        '{3'd3, 6'd1,  "D"}, '{3'd1, 6'd0,  "E"}, '{3'd4, 6'd4,  "F"},
        '{3'd3, 6'd3,  "G"}, '{3'd4, 6'd0,  "H"}, '{3'd2, 6'd0,  "I"},
        '{3'd4, 6'd14, "J"}, '{3'd3, 6'd5,  "K"}, '{3'd4, 6'd2,  "L"},
        '{3'd2, 6'd3,  "M"}, '{3'd2, 6'd1,  "N"}, '{3'd3, 6'd7,  "O"},
        '{3'd4, 6'd6,  "P"}, '{3'd4, 6'd11, "Q"}, '{3'd3, 6'd2,  "R"},
        '{3'd3, 6'd0,  "S"}, '{3'd1, 6'd1,  "T"}, '{3'd3, 6'd4,  "U"},
        '{3'd4, 6'd8,  "V"}, '{3'd3, 6'd6,  "W"}, '{3'd4, 6'd9,  "X"},
        '{3'd4, 6'd13, "Y"}, '{3'd4, 6'd3,  "Z"},
        '{3'd5, 6'd31, "0"}, '{3'd5, 6'd30, "1"}, '{3'd5, 6'd28, "2"},
        '{3'd5, 6'd24, "3"}, '{3'd5, 6'd16, "4"}, '{3'd5, 6'd0,  "5"},
        '{3'd5, 6'd1,  "6"}, '{3'd5, 6'd3,  "7"}, '{3'd5, 6'd7,  "8"},
        '{3'd5, 6'd15, "9"}
    };

    // character of a pending symbol, zero when it is no code
    function automatic logic [CHAR_W-1:0] morse_lookup(
        input logic [SYM_LEN_W-1:0] len,
        input logic [SYM_W-1:0]     bits
    );
        logic [CHAR_W-1:0] ch;
        ch = CHAR_NONE;
        for (int i = 0; i < CODE_COUNT; i++) begin
            if (MORSE_TABLE[i].len == len && MORSE_TABLE[i].bits == bits) begin
                ch = MORSE_TABLE[i].ch;
            end
        end
        return ch;
    endfunction

endpackage

// ===== sv/mktd_if.sv =====
// valid/ready channel interfaces for key words and text words
`timescale 1ns / 1ps

interface mktd_key_if;
    logic valid;
    logic ready;
    logic dash_level;
    logic dot_level;
    logic space_level;
    logic back_level;

    modport source (output valid, dash_level, dot_level, space_level, back_level,
                    input ready);
    modport sink   (input valid, dash_level, dot_level, space_level, back_level,
                    output ready);
endinterface

interface mktd_text_if;
    logic       valid;
    logic       ready;
    logic [2:0] text_event;
    logic [7:0] text_char;
    logic       back_deleted;
    logic [4:0] text_length;
    logic [2:0] symbol_length;
    logic [5:0] symbol_pattern;

    modport source (output valid, text_event, text_char, back_deleted, text_length,
                    symbol_length, symbol_pattern,
                    input ready);
    modport sink   (input valid, text_event, text_char, back_deleted, text_length,
                    symbol_length, symbol_pattern,
                    output ready);
endinterface

// ===== sv/morse_key_text_decoder.sv =====
// a key word's text word is held in the result register and offered in the cycle after acceptance
// throughput: one key word per cycle while the text side does not stall, the decode is one registered step
// the key side stays ready while the result register is empty or being taken
// reset (i_rst_n low, synchronous): keys released, symbol and text empty,
// back_enable set to 1, result register empty
`timescale 1ns / 1ps

`include "morse_key_text_decoder_macros.svh"

module morse_key_text_decoder
    import mktd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    mktd_key_if.sink           i_key,
    mktd_text_if.source        o_text,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    t_state  r_state;
    t_state  n_state;
    t_result r_out;
    t_result n_out;
    logic    r_out_valid;
    logic    r_back_enable;
    logic    key_accept;
    logic    cfg_write;
    t_keys   keys;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr == ADDR_BACK_ENABLE);
    assign prdata    = (paddr == ADDR_BACK_ENABLE) ? PDATA_W'(r_back_enable) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_back_enable <= 1'b1;
        end else if (cfg_write) begin
            r_back_enable <= pwdata[0];
        end
    end

    // key word handshake
    assign i_key.ready = !r_out_valid || o_text.ready;
    assign key_accept  = i_key.valid && i_key.ready;

    assign keys.dash_level  = i_key.dash_level;
    assign keys.dot_level   = i_key.dot_level;
    assign keys.space_level = i_key.space_level;
    assign keys.back_level  = i_key.back_level;

    mktd_decode u_decode (
        .i_state       (r_state),
        .i_keys        (keys),
        .i_back_enable (r_back_enable),
        .o_state       (n_state),
        .o_result      (n_out)
    );

    // decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.prev_dash  <= 1'b1;
            r_state.prev_dot   <= 1'b1;
            r_state.prev_space <= 1'b1;
            r_state.sym_bits   <= '0;
            r_state.sym_count  <= '0;
            r_state.text_count <= '0;
        end else if (key_accept) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (key_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_text.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (key_accept) begin
            r_out <= n_out;
        end
    end

    assign o_text.valid          = r_out_valid;
    assign o_text.text_event     = r_out.text_event;
    assign o_text.text_char      = r_out.text_char;
    assign o_text.back_deleted   = r_out.back_deleted;
    assign o_text.text_length    = r_out.text_length;
    assign o_text.symbol_length  = r_out.symbol_length;
    assign o_text.symbol_pattern = r_out.symbol_pattern;

    // checks
    `MKTD_ASSERT_ALWAYS(a_reset_clears, !i_rst_n |=> (!r_out_valid && r_state.text_count == '0), "reset did not clear result and text")
    `MKTD_ASSERT_CLK(a_text_bound, r_state.text_count <= TEXT_LEN_W'(TEXT_CAPACITY), "text count beyond capacity")
    `MKTD_ASSERT_CLK(a_out_tracks_state, r_out_valid |-> (r_out.text_length == r_state.text_count && r_out.symbol_length == r_state.sym_count), "result word out of step with state")
    `MKTD_ASSERT_CLK(a_stall_holds_state, (r_out_valid && !o_text.ready) |=> $stable(r_state), "state moved while result stalled")
    `MKTD_ASSERT_CLK(a_restart_length, (r_out_valid && r_out.text_event == EV_RESTART) |-> (r_out.text_length == TEXT_LEN_W'(1) - TEXT_LEN_W'(r_out.back_deleted)), "restart left wrong text length")

endmodule

// ===== sv/mktd_decode.sv =====
// key edge detection, symbol building, morse decode and text edit logic
`timescale 1ns / 1ps

module mktd_decode
    import mktd_pkg::*;
(
    input  t_state  i_state,
    input  t_keys   i_keys,
    input  logic    i_back_enable,
    output t_state  o_state,
    output t_result o_result
);

    logic                 dash_fall;
    logic                 dot_fall;
    logic                 space_fall;
    logic                 is_dash;
    logic [CHAR_W-1:0]    sym_char;
    logic [TEXT_LEN_W:0]  text_plus;
    t_state               n_state;
    t_result              n_result;

    // falling edges, dash over dot over space
    assign dash_fall  = !i_keys.dash_level && i_state.prev_dash;
    assign dot_fall   = !i_keys.dot_level && i_state.prev_dot;
    assign space_fall = !i_keys.space_level && i_state.prev_space;
    assign is_dash    = dash_fall;

    // decoded character, an empty symbol is a space
    assign sym_char  = (i_state.sym_count == '0) ? CHAR_SPACE
                     : morse_lookup(i_state.sym_count, i_state.sym_bits);
    assign text_plus = {1'b0, i_state.text_count} + (TEXT_LEN_W+1)'(1);

    // next state and result word
    always_comb begin
        n_state                 = i_state;
        n_result.text_event     = EV_NONE;
        n_result.text_char      = CHAR_NONE;
        n_result.back_deleted   = 1'b0;

        if (dash_fall || dot_fall) begin
            if (i_state.sym_count >= SYM_LEN_W'(SYMBOL_MAX)) begin
                n_state.sym_count = SYM_LEN_W'(1);
                n_state.sym_bits  = SYM_W'(is_dash);
            end else begin
                n_state.sym_bits  = i_state.sym_bits | (SYM_W'(is_dash) << i_state.sym_count);
                n_state.sym_count = i_state.sym_count + SYM_LEN_W'(1);
            end
        end else if (space_fall) begin
            if (sym_char != CHAR_NONE) begin
                if (text_plus > (TEXT_LEN_W+1)'(TEXT_CAPACITY)) begin
                    n_state.text_count  = TEXT_LEN_W'(1);
                    n_result.text_event = EV_RESTART;
                end else begin
                    n_state.text_count  = text_plus[TEXT_LEN_W-1:0];
                    n_result.text_event = EV_APPEND;
                end
                n_result.text_char = sym_char;
            end else if (i_state.sym_count == SYM_LEN_W'(SYMBOL_MAX)
                         && i_state.sym_bits == PATTERN_DOTS) begin
                if (i_state.text_count != '0) begin
                    n_state.text_count  = i_state.text_count - TEXT_LEN_W'(1);
                    n_result.text_event = EV_DELETE;
                end
            end else if (i_state.sym_count == SYM_LEN_W'(SYMBOL_MAX)
                         && i_state.sym_bits == PATTERN_DASHES) begin
                n_state.text_count  = '0;
                n_result.text_event = EV_CLEAR;
            end
            n_state.sym_bits  = '0;
            n_state.sym_count = '0;
        end

        // held back key deletes on every tick while back_enable is set and the text is not empty
        if (i_back_enable && !i_keys.back_level && n_state.text_count != '0) begin
            n_state.text_count    = n_state.text_count - TEXT_LEN_W'(1);
            n_result.back_deleted = 1'b1;
        end

        n_state.prev_dash  = i_keys.dash_level;
        n_state.prev_dot   = i_keys.dot_level;
        n_state.prev_space = i_keys.space_level;

        n_result.text_length    = n_state.text_count;
        n_result.symbol_length  = n_state.sym_count;
        n_result.symbol_pattern = n_state.sym_bits;
    end

    assign o_state  = n_state;
    assign o_result = n_result;

endmodule

// ===== sim/mktd_text_checker.sv =====
// checker for the morse key text decoder: watches the channels, predicts and compares
`timescale 1ns / 1ps

module mktd_text_checker
    import mktd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    mktd_key_if                key_mon,
    mktd_text_if               text_mon,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    input  logic [PDATA_W-1:0] prdata,
    input  logic               pready,
    output int                 o_fail_count,
    output int                 o_words_due
);

    // decoder copy: register, key history, pending symbol and text size
    logic                  back_en_m;
    logic                  last_dash;
    logic                  last_dot;
    logic                  last_space;
    logic [SYM_W-1:0]      sym_bits_m;
    logic [SYM_LEN_W-1:0]  sym_len_m;
    logic [TEXT_LEN_W-1:0] text_len_m;

    // text words predicted and not yet seen
    t_result text_due [$];

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
        o_fail_count = o_fail_count + 1;
    endtask

    // itu letters and digits, bit i set for a dash at position i
    function automatic logic [CHAR_W-1:0] itu_char(input logic [SYM_LEN_W-1:0] n,
                                                   input logic [SYM_W-1:0]     b);
        logic [CHAR_W-1:0] c;
        case ({n, b})
            {3'd1, 6'd0}:  c = "E";
            {3'd1, 6'd1}:  c = "T";
            {3'd2, 6'd0}:  c = "I";
            {3'd2, 6'd1}:  c = "N";
            {3'd2, 6'd2}:  c = "A";
            {3'd2, 6'd3}:  c = "M";
            {3'd3, 6'd0}:  c = "S";
            {3'd3, 6'd1}:  c = "D";
            {3'd3, 6'd2}:  c = "R";
            {3'd3, 6'd3}:  c = "G";
            {3'd3, 6'd4}:  c = "U";
            {3'd3, 6'd5}:  c = "K";
            {3'd3, 6'd6}:  c = "W";
            {3'd3, 6'd7}:  c = "O";
            {3'd4, 6'd0}:  c = "H";
            {3'd4, 6'd1}:  c = "B";
            {3'd4, 6'd2}:  c = "L";
            {3'd4, 6'd3}:  c = "Z";
            {3'd4, 6'd4}:  c = "F";
            {3'd4, 6'd5}:  c = "C";
            {3'd4, 6'd6}:  c = "P";
            {3'd4, 6'd8}:  c = "V";
            {3'd4, 6'd9}:  c = "X";
            {3'd4, 6'd11}: c = "Q";
            {3'd4, 6'd13}: c = "Y";
            {3'd4, 6'd14}: c = "J";
            {3'd5, 6'd0}:  c = "5";
            {3'd5, 6'd1}:  c = "6";
            {3'd5, 6'd3}:  c = "7";
            {3'd5, 6'd7}:  c = "8";
            {3'd5, 6'd15}: c = "9";
            {3'd5, 6'd31}: c = "0";
            {3'd5, 6'd30}: c = "1";
            {3'd5, 6'd28}: c = "2";
            {3'd5, 6'd24}: c = "3";
            {3'd5, 6'd16}: c = "4";
            default:       c = CHAR_NONE;
        endcase
        return c;
    endfunction

    // shift one element in, a full symbol restarts with it
    task automatic add_element(input logic is_dash);
        if (int'(sym_len_m) >= SYMBOL_MAX) begin
            sym_len_m  = 3'd1;
            sym_bits_m = {5'd0, is_dash};
        end else begin
            sym_bits_m[sym_len_m] = is_dash;
            sym_len_m             = sym_len_m + 3'd1;
        end
    endtask

    // one key tick: tone by priority, then the held back key
    task automatic decode_keys(input t_keys k, output t_result r);
        t_text_event       ev;
        logic [CHAR_W-1:0] ch;
        logic              back_del;
        logic [CHAR_W-1:0] sym;
        ev       = EV_NONE;
        ch       = CHAR_NONE;
        back_del = 1'b0;
        if (!k.dash_level && last_dash) begin
            add_element(1'b1);
        end else if (!k.dot_level && last_dot) begin
            add_element(1'b0);
        end else if (!k.space_level && last_space) begin
            sym = (sym_len_m == '0) ? CHAR_SPACE : itu_char(sym_len_m, sym_bits_m);
            if (sym != CHAR_NONE) begin
                if (int'(text_len_m) + 1 > TEXT_CAPACITY) begin
                    text_len_m = 5'd1;
                    ev         = EV_RESTART;
                end else begin
                    text_len_m = text_len_m + 5'd1;
                    ev         = EV_APPEND;
                end
                ch = sym;
            end else if (int'(sym_len_m) == SYMBOL_MAX && sym_bits_m == PATTERN_DOTS) begin
                if (text_len_m != '0) begin
                    text_len_m = text_len_m - 5'd1;
                    ev         = EV_DELETE;
                end
            end else if (int'(sym_len_m) == SYMBOL_MAX && sym_bits_m == PATTERN_DASHES) begin
                text_len_m = '0;
                ev         = EV_CLEAR;
            end
            sym_bits_m = '0;
            sym_len_m  = '0;
        end
        if (back_en_m && !k.back_level && text_len_m != '0) begin
            text_len_m = text_len_m - 5'd1;
            back_del   = 1'b1;
        end
        last_dash  = k.dash_level;
        last_dot   = k.dot_level;
        last_space = k.space_level;
        r.text_event     = ev;
        r.text_char      = ch;
        r.back_deleted   = back_del;
        r.text_length    = text_len_m;
        r.symbol_length  = sym_len_m;
        r.symbol_pattern = sym_bits_m;
    endtask

    // sample everything at the rising edge
    always @(posedge i_clk) begin
        t_keys   k;
        t_result r;
        t_result want;
        if (!i_rst_n) begin
            back_en_m  = 1'b1;
            last_dash  = 1'b1;
            last_dot   = 1'b1;
            last_space = 1'b1;
            sym_bits_m = '0;
            sym_len_m  = '0;
            text_len_m = '0;
            text_due.delete();
        end else begin
            // register port, only index zero exists
            if (psel && penable && pready && paddr == ADDR_BACK_ENABLE) begin
                if (pwrite) begin
                    back_en_m = pwdata[0];
                end else if (prdata !== PDATA_W'(back_en_m)) begin
                    report_mismatch("back_enable read", prdata, PDATA_W'(back_en_m));
                end
            end

            // text word out, oldest prediction first
            if (text_mon.valid && text_mon.ready) begin
                if (text_due.size() == 0) begin
                    report_mismatch("text word with nothing due",
                                    32'(text_mon.text_event), 32'd0);
                end else begin
                    want = text_due.pop_front();
                    if (text_mon.text_event !== want.text_event)
                        report_mismatch("text_event", 32'(text_mon.text_event),
                                        32'(want.text_event));
                    if (text_mon.text_char !== want.text_char)
                        report_mismatch("text_char", 32'(text_mon.text_char),
                                        32'(want.text_char));
                    if (text_mon.back_deleted !== want.back_deleted)
                        report_mismatch("back_deleted", 32'(text_mon.back_deleted),
                                        32'(want.back_deleted));
                    if (text_mon.text_length !== want.text_length)
                        report_mismatch("text_length", 32'(text_mon.text_length),
                                        32'(want.text_length));
                    if (text_mon.symbol_length !== want.symbol_length)
                        report_mismatch("symbol_length", 32'(text_mon.symbol_length),
                                        32'(want.symbol_length));
                    if (text_mon.symbol_pattern !== want.symbol_pattern)
                        report_mismatch("symbol_pattern", 32'(text_mon.symbol_pattern),
                                        32'(want.symbol_pattern));
                end
            end

            // key word in, predict its text word
            if (key_mon.valid && key_mon.ready) begin
                k.dash_level  = key_mon.dash_level;
                k.dot_level   = key_mon.dot_level;
                k.space_level = key_mon.space_level;
                k.back_level  = key_mon.back_level;
                decode_keys(k, r);
                text_due.push_back(r);
            end
        end
        o_words_due = text_due.size();
    end

endmodule

// ===== sim/tb_top.sv =====
// testbench top for the morse key text decoder: clock, reset, key stimulus and verdict
`timescale 1ns / 1ps

module tb_top;
    import mktd_pkg::*;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    int                 fail_count;
    int                 words_due;

    mktd_key_if  key_bus ();
    mktd_text_if text_bus ();

    morse_key_text_decoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_key   (key_bus.sink),
        .o_text  (text_bus.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    mktd_text_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .key_mon      (key_bus),
        .text_mon     (text_bus),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_fail_count (fail_count),
        .o_words_due  (words_due)
    );

    // stimulus shaping state
    int   sent_count;
    int   gap_pct;
    logic quiet;
    logic back_on;
    logic lvl_dash;
    logic lvl_dot;
    logic lvl_space;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard limit on the run
    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    // text side backpressure in bursts
    initial begin
        text_bus.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            text_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
            if (!quiet && $urandom_range(0, 3) != 0) begin
                text_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    // one key word, held until taken, then maybe a gap
    task automatic send_keys(input logic dash, input logic dot, input logic space,
                             input logic back);
        key_bus.valid       <= 1'b1;
        key_bus.dash_level  <= dash;
        key_bus.dot_level   <= dot;
        key_bus.space_level <= space;
        key_bus.back_level  <= back;
        @(posedge i_clk);
        while (!key_bus.ready) @(posedge i_clk);
        sent_count = sent_count + 1;
        lvl_dash   = dash;
        lvl_dot    = dot;
        lvl_space  = space;
        if (!quiet && gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
            key_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] a, input logic [PDATA_W-1:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= a;
        pwdata  <= d;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apb_read(input logic [PADDR_W-1:0] a);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= a;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // stop sending and wait until every text word is out
    task automatic drain_words();
        key_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (words_due != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // back key mostly released while it counts, often pressed while ignored
    function automatic logic pick_back();
        if (back_on)
            return ($urandom_range(0, 99) < 3) ? 1'b0 : 1'b1;
        return 1'($urandom_range(0, 1));
    endfunction

    // one dot or dash, released first if still down, sometimes held
    task automatic key_element(input logic is_dash);
        int hold;
        hold = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1;
        if (is_dash ? !lvl_dash : !lvl_dot)
            send_keys(1'b1, 1'b1, 1'b1, pick_back());
        repeat (hold) send_keys(!is_dash, is_dash, 1'b1, pick_back());
    endtask

    task automatic key_space();
        if (!lvl_space)
            send_keys(1'b1, 1'b1, 1'b1, pick_back());
        send_keys(1'b1, 1'b1, 1'b0, pick_back());
    endtask

    task automatic key_symbol(input int len, input logic [15:0] pat);
        for (int i = 0; i < len; i++) key_element(pat[i]);
    endtask

    // mostly keyed characters, with noise and broken symbols mixed in
    task automatic run_random(input int n_items);
        int          start;
        int          kind;
        int          k;
        logic [15:0] pat;
        logic [3:0]  lv;
        start = sent_count;
        while (sent_count - start < n_items) begin
            if ($urandom_range(0, 15) == 0)
                case ($urandom_range(0, 2))
                    0:       gap_pct = 0;
                    1:       gap_pct = 8;
                    default: gap_pct = 25;
                endcase
            kind = $urandom_range(0, 99);
            pat  = 16'($urandom());
            if (kind < 40) begin
                key_symbol($urandom_range(1, 4), pat);
                key_space();
            end else if (kind < 50) begin
                k   = $urandom_range(0, 5);
                pat = $urandom_range(0, 1) ? 16'((1 << k) - 1) : 16'(5'h1f & ~((1 << k) - 1));
                key_symbol(5, pat);
                key_space();
            end else if (kind < 58) begin
                key_symbol($urandom_range(5, 6), pat);
                key_space();
            end else if (kind < 64) begin
                key_symbol(6, 16'h0000);
                key_space();
            end else if (kind < 67) begin
                key_symbol(6, 16'h003f);
                key_space();
            end else if (kind < 74) begin
                key_symbol($urandom_range(7, 9), pat);
                key_space();
            end else if (kind < 82) begin
                key_space();
            end else if (kind < 90) begin
                key_symbol($urandom_range(1, 6), pat);
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    lv = 4'($urandom_range(0, 15));
                    send_keys(lv[3], lv[2], lv[1], lv[0]);
                end
            end
        end
    endtask

    // main sequence
    initial begin
        int wait_cycles;
        sent_count = 0;
        gap_pct    = 20;
        quiet      = 1'b0;
        back_on    = 1'b1;
        lvl_dash   = 1'b1;
        lvl_dot    = 1'b1;
        lvl_space  = 1'b1;

        key_bus.valid       <= 1'b0;
        key_bus.dash_level  <= 1'b1;
        key_bus.dot_level   <= 1'b1;
        key_bus.space_level <= 1'b1;
        key_bus.back_level  <= 1'b1;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        i_rst_n <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        apb_write(ADDR_BACK_ENABLE, 32'd1);
        apb_read(ADDR_BACK_ENABLE);

        // directed: priority, back key, overflow, unknown symbol
        send_keys(1'b1, 1'b1, 1'b1, 1'b1);
        send_keys(1'b0, 1'b0, 1'b0, 1'b1);  // all tone keys at once, dash wins
        send_keys(1'b1, 1'b1, 1'b1, 1'b1);
        send_keys(1'b1, 1'b1, 1'b0, 1'b1);  // append T
        send_keys(1'b1, 1'b1, 1'b1, 1'b0);  // back deletes it
        send_keys(1'b1, 1'b1, 1'b1, 1'b0);  // back held on empty text
        send_keys(1'b1, 1'b1, 1'b0, 1'b0);  // empty symbol space, then back
        send_keys(1'b1, 1'b0, 1'b0, 1'b1);  // dot element, space still held down from before
        send_keys(1'b0, 1'b1, 1'b1, 1'b1);
        send_keys(1'b1, 1'b0, 1'b1, 1'b1);
        send_keys(1'b0, 1'b1, 1'b1, 1'b1);
        send_keys(1'b1, 1'b0, 1'b1, 1'b1);
        send_keys(1'b0, 1'b1, 1'b1, 1'b1);  // six elements pending
        send_keys(1'b1, 1'b0, 1'b1, 1'b1);  // seventh restarts the symbol
        send_keys(1'b1, 1'b1, 1'b0, 1'b1);  // append E
        send_keys(1'b0, 1'b1, 1'b1, 1'b1);
        send_keys(1'b1, 1'b0, 1'b1, 1'b1);
        send_keys(1'b0, 1'b1, 1'b1, 1'b1);
        send_keys(1'b1, 1'b0, 1'b1, 1'b1);
        send_keys(1'b0, 1'b1, 1'b1, 1'b1);
        send_keys(1'b1, 1'b0, 1'b1, 1'b1);
        send_keys(1'b1, 1'b1, 1'b0, 1'b1);  // unknown symbol, only cleared
        send_keys(1'b0, 1'b1, 1'b1, 1'b1);
        send_keys(1'b1, 1'b1, 1'b0, 1'b1);  // append T
        drain_words();

        // back key ignored
        apb_write(ADDR_BACK_ENABLE, 32'd0);
        apb_read(ADDR_BACK_ENABLE);
        back_on = 1'b0;
        run_random(350);
        drain_words();

        // writes to unused addresses leave the register alone
        apb_write(2'd2, 32'hffff_ffff);
        apb_write(2'd3, 32'h0000_0001);
        apb_read(ADDR_BACK_ENABLE);
        run_random(350);
        drain_words();

        // back key active again, upper data bits set
        apb_write(ADDR_BACK_ENABLE, 32'hffff_ffff);
        apb_read(ADDR_BACK_ENABLE);
        back_on = 1'b1;
        run_random(375);
        drain_words();

        // last stretch runs without idling on either side
        quiet   = 1'b1;
        gap_pct = 0;
        apb_write(ADDR_BACK_ENABLE, 32'd1);
        run_random(375);

        key_bus.valid <= 1'b0;
        @(posedge i_clk);
        wait_cycles = 0;
        while (words_due != 0 && wait_cycles < 1000) begin
            @(posedge i_clk);
            wait_cycles = wait_cycles + 1;
        end
        repeat (4) @(posedge i_clk);

        if (fail_count == 0 && words_due == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/mktd_pkg.sv
sv/mktd_if.sv
sv/mktd_decode.sv
sv/morse_key_text_decoder.sv
sim/mktd_text_checker.sv
sim/tb_top.sv
